// File: rtl/core/nmea_sentence_receiver_macros.svh
// assertion macros shared by the checker
`ifndef NMEA_SENTENCE_RECEIVER_MACROS_SVH
`define NMEA_SENTENCE_RECEIVER_MACROS_SVH

// same-cycle implication
`define NMEA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nmea receiver check failed");

// next-cycle implication
`define NMEA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nmea receiver check failed");

`endif

// File: rtl/core/nmea_rx_pkg.sv
`timescale 1ns / 1ps

package nmea_rx_pkg;

	localparam logic [2:0] PH_WAIT = 3'd0;
	localparam logic [2:0] PH_RECV = 3'd1;
	localparam logic [2:0] PH_HIGH = 3'd2;
	localparam logic [2:0] PH_LOW  = 3'd3;
	localparam logic [2:0] PH_FULL = 3'd4;

	localparam logic [2:0] EV_IGNORED = 3'd0;
	localparam logic [2:0] EV_START   = 3'd1;
	localparam logic [2:0] EV_CHAR    = 3'd2;
	localparam logic [2:0] EV_SEP     = 3'd3;
	localparam logic [2:0] EV_ACCEPT  = 3'd4;
	localparam logic [2:0] EV_REJECT  = 3'd5;
	localparam logic [2:0] EV_ABORT   = 3'd6;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	typedef struct packed {
		logic [2:0] event_res;
		logic [7:0] char_out;
		logic [6:0] position;
		logic [4:0] field_count;
		logic       is_dollar;
		logic [7:0] checksum_calc;
	} res_t;

	// returns {bad, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b0, 4'(c - 8'h30)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b0, 4'(c - 8'h37)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b0, 4'(c - 8'h57)};
		return r;
	endfunction

endpackage

// File: rtl/core/nmea_sentence_receiver.sv
`timescale 1ns / 1ps
// latency: a byte transferred at one edge shows its result from the next cycle on
// throughput: one byte per cycle unless the output stalls; the sentence state updates in the
// transfer cycle and the result sits in a single output register that reloads while
// being drained; reset: arst_n clears the parser to waiting for a start byte and
// empties the output register; no sweep, the block takes bytes right after reset

module nmea_sentence_receiver #(
	parameter int unsigned BUFFER_SIZE = 85,
	parameter int unsigned MAX_FIELDS  = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] event_res,
	output logic [7:0] char_out,
	output logic [6:0] position,
	output logic [4:0] field_count,
	output logic       is_dollar,
	output logic [7:0] checksum_calc
);

	nmea_rx_pkg::res_t res;
	nmea_rx_pkg::res_t res_q;
	logic              out_valid_q;
	logic              step;

	assign in_ready = !out_valid_q || out_ready;
	assign step     = in_valid && in_ready;

	nmea_rx_fsm #(
		.BUFFER_SIZE(BUFFER_SIZE),
		.MAX_FIELDS (MAX_FIELDS)
	) u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.rx_byte(rx_byte),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			res_q <= res;
	end

	assign out_valid     = out_valid_q;
	assign event_res     = res_q.event_res;
	assign char_out      = res_q.char_out;
	assign position      = res_q.position;
	assign field_count   = res_q.field_count;
	assign is_dollar     = res_q.is_dollar;
	assign checksum_calc = res_q.checksum_calc;

endmodule

// File: rtl/core/nmea_rx_fsm.sv
`timescale 1ns / 1ps

module nmea_rx_fsm #(
	parameter int unsigned BUFFER_SIZE = 85,
	parameter int unsigned MAX_FIELDS  = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	output nmea_rx_pkg::res_t   res
);

	logic [2:0] phase_q, phase_d;
	logic [6:0] write_pos_q, write_pos_d;
	logic [4:0] fields_q, fields_d;
	logic [7:0] xsum_q, xsum_d;
	logic [3:0] given_hi_q, given_hi_d;
	logic       dollar_q, dollar_d;
	logic [6:0] pos_inc;
	logic [4:0] hex;
	logic [2:0] ev;
	logic [7:0] ch;
	logic [6:0] pos;

	assign pos_inc = write_pos_q + 7'd1;
	assign hex     = nmea_rx_pkg::hex_decode(rx_byte);

	always_comb begin
		phase_d     = phase_q;
		write_pos_d = write_pos_q;
		fields_d    = fields_q;
		xsum_d      = xsum_q;
		given_hi_d  = given_hi_q;
		dollar_d    = dollar_q;
		ev          = nmea_rx_pkg::EV_IGNORED;
		ch          = 8'd0;
		pos         = 7'd0;
		if (rx_byte == nmea_rx_pkg::CH_DOLLAR || rx_byte == nmea_rx_pkg::CH_BANG) begin
			dollar_d    = (rx_byte == nmea_rx_pkg::CH_DOLLAR);
			write_pos_d = 7'd0;
			fields_d    = 5'd0;
			xsum_d      = 8'd0;
			given_hi_d  = 4'd0;
			phase_d     = nmea_rx_pkg::PH_RECV;
			ev          = nmea_rx_pkg::EV_START;
		end else begin
			case (phase_q)
				nmea_rx_pkg::PH_RECV, nmea_rx_pkg::PH_FULL: begin
					if (rx_byte == nmea_rx_pkg::CH_STAR) begin
						phase_d = nmea_rx_pkg::PH_HIGH;
					end else if (phase_q == nmea_rx_pkg::PH_RECV) begin
						xsum_d = xsum_q ^ rx_byte;
						pos    = write_pos_q;
						if (rx_byte == nmea_rx_pkg::CH_COMMA) begin
							ev = nmea_rx_pkg::EV_SEP;
							if (fields_q < 5'(MAX_FIELDS))
								fields_d = fields_q + 5'd1;
						end else begin
							ev = nmea_rx_pkg::EV_CHAR;
							ch = rx_byte;
						end
						write_pos_d = pos_inc;
						if (pos_inc >= 7'(BUFFER_SIZE))
							phase_d = nmea_rx_pkg::PH_FULL;
					end else begin
						ev      = nmea_rx_pkg::EV_ABORT;
						phase_d = nmea_rx_pkg::PH_WAIT;
					end
				end
				nmea_rx_pkg::PH_HIGH: begin
					if (hex[4]) begin
						ev      = nmea_rx_pkg::EV_REJECT;
						phase_d = nmea_rx_pkg::PH_WAIT;
					end else begin
						given_hi_d = hex[3:0];
						phase_d    = nmea_rx_pkg::PH_LOW;
					end
				end
				nmea_rx_pkg::PH_LOW: begin
					ev = nmea_rx_pkg::EV_REJECT;
					if (!hex[4] && {given_hi_q, hex[3:0]} == xsum_q)
						ev = nmea_rx_pkg::EV_ACCEPT;
					phase_d = nmea_rx_pkg::PH_WAIT;
				end
				default: begin
				end
			endcase
		end
	end

	assign res.event_res     = ev;
	assign res.char_out      = ch;
	assign res.position      = pos;
	assign res.field_count   = fields_d;
	assign res.is_dollar     = dollar_d;
	assign res.checksum_calc = xsum_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= nmea_rx_pkg::PH_WAIT;
			write_pos_q <= 7'd0;
			fields_q    <= 5'd0;
			xsum_q      <= 8'd0;
			given_hi_q  <= 4'd0;
			dollar_q    <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			write_pos_q <= write_pos_d;
			fields_q    <= fields_d;
			xsum_q      <= xsum_d;
			given_hi_q  <= given_hi_d;
			dollar_q    <= dollar_d;
		end
	end

endmodule

// File: rtl/core/nmea_rx_checker.sv
`timescale 1ns / 1ps
`include "nmea_sentence_receiver_macros.svh"

module nmea_rx_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] rx_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] event_res,
	input logic [7:0] char_out,
	input logic [6:0] position,
	input logic [4:0] field_count,
	input logic       is_dollar,
	input logic [7:0] checksum_calc
);

	logic        out_stall;
	logic [31:0] res_bus;
	logic        dollar_byte;
	logic        start_xfer;
	logic        fresh;
	logic        is_char;
	logic        is_sep;

	assign out_stall   = out_valid && !out_ready;
	assign res_bus     = {event_res, char_out, position, field_count, is_dollar, checksum_calc};
	assign dollar_byte = (rx_byte == nmea_rx_pkg::CH_DOLLAR);
	assign start_xfer  = in_valid && in_ready &&
		(dollar_byte || rx_byte == nmea_rx_pkg::CH_BANG);
	assign fresh       = out_valid && event_res == nmea_rx_pkg::EV_START &&
		field_count == 5'd0 && checksum_calc == 8'd0;
	assign is_char     = (event_res == nmea_rx_pkg::EV_CHAR);
	assign is_sep      = (event_res == nmea_rx_pkg::EV_SEP);

	// a stalled result holds
	`NMEA_ASSERT_NXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable(res_bus))

	// a start byte always gives a fresh sentence
	`NMEA_ASSERT_NXT(a_start_clears, clk, arst_n, start_xfer, fresh)

	// the start mark decides the sentence kind
	`NMEA_ASSERT_NXT(a_start_kind, clk, arst_n, start_xfer, is_dollar == $past(dollar_byte))

	// only stored bytes carry data
	`NMEA_ASSERT_IMP(a_char_only, clk, arst_n, out_valid && !is_char, char_out == 8'd0)

	// position only for stored bytes and separators
	`NMEA_ASSERT_IMP(a_pos_only, clk, arst_n, out_valid && !is_char && !is_sep, position == 7'd0)

endmodule

bind nmea_sentence_receiver nmea_rx_checker u_nmea_rx_checker (.*);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int BUF_LEN   = 85;
	localparam int FIELD_MAX = 20;
	localparam int RAND_BYTES = 400;

	typedef struct {
		logic [7:0] b;
		bit         fixed;   // result written out below instead of predicted
		logic [2:0] ev;
		logic       dol;
	} plan_item_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [7:0] rx_byte   = 8'h00;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [2:0] event_res;
	logic [7:0] char_out;
	logic [6:0] position;
	logic [4:0] field_count;
	logic       is_dollar;
	logic [7:0] checksum_calc;

	nmea_sentence_receiver u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_res    (event_res),
		.char_out     (char_out),
		.position     (position),
		.field_count  (field_count),
		.is_dollar    (is_dollar),
		.checksum_calc(checksum_calc)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// short sentences: idle bytes, both start marks, good, bad and mismatched checksums
	plan_item_t dir_rows [26] = '{
		'{"A",   1'b1, nmea_rx_pkg::EV_IGNORED, 1'b0},
		'{8'hFF, 1'b1, nmea_rx_pkg::EV_IGNORED, 1'b0},
		'{"!",   1'b1, nmea_rx_pkg::EV_START,   1'b0},
		'{"*",   1'b1, nmea_rx_pkg::EV_IGNORED, 1'b0},
		'{"g",   1'b1, nmea_rx_pkg::EV_REJECT,  1'b0},
		'{"$",   1'b1, nmea_rx_pkg::EV_START,   1'b1},
		'{"*",   1'b1, nmea_rx_pkg::EV_IGNORED, 1'b1},
		'{"0",   1'b1, nmea_rx_pkg::EV_IGNORED, 1'b1},
		'{"0",   1'b1, nmea_rx_pkg::EV_ACCEPT,  1'b1},
		'{"$",   1'b1, nmea_rx_pkg::EV_START,   1'b1},
		'{"c",   1'b0, nmea_rx_pkg::EV_IGNORED, 1'b0},
		'{",",   1'b0, nmea_rx_pkg::EV_IGNORED, 1'b0},
		'{"*",   1'b0, nmea_rx_pkg::EV_IGNORED, 1'b0},
		'{"4",   1'b0, nmea_rx_pkg::EV_IGNORED, 1'b0},
		'{"f",   1'b0, nmea_rx_pkg::EV_IGNORED, 1'b0},
		'{"!",   1'b1, nmea_rx_pkg::EV_START,   1'b0},
		'{"*",   1'b1, nmea_rx_pkg::EV_IGNORED, 1'b0},
		'{"0",   1'b1, nmea_rx_pkg::EV_IGNORED, 1'b0},
		'{"x",   1'b1, nmea_rx_pkg::EV_REJECT,  1'b0},
		'{"$",   1'b1, nmea_rx_pkg::EV_START,   1'b1},
		'{"*",   1'b1, nmea_rx_pkg::EV_IGNORED, 1'b1},
		'{"0",   1'b1, nmea_rx_pkg::EV_IGNORED, 1'b1},
		'{"1",   1'b1, nmea_rx_pkg::EV_REJECT,  1'b1},
		'{"!",   1'b1, nmea_rx_pkg::EV_START,   1'b0},
		'{"*",   1'b1, nmea_rx_pkg::EV_IGNORED, 1'b0},
		'{"$",   1'b1, nmea_rx_pkg::EV_START,   1'b1}
	};

	plan_item_t        plan [$];
	nmea_rx_pkg::res_t parsed_q [$];

	// parser state mirror
	logic [2:0] ph      = nmea_rx_pkg::PH_WAIT;
	logic [6:0] wpos    = '0;
	logic [4:0] nfields = '0;
	logic [7:0] xor_acc = '0;
	logic [7:0] given   = '0;
	logic       dol     = 1'b0;

	int acc_count = 0;
	int hold_left = 0;
	bit pressed   = 1'b0;
	int errors    = 0;
	int n_accept  = 0;
	int n_reject  = 0;
	int n_abort   = 0;
	int next_idx  = 0;
	logic calm;

	assign calm = (acc_count >= 250) && (acc_count < 330);

	// {bad, value} of one hex digit
	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return {1'b0, c[3:0]};
		if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
			return {1'b0, 4'(c[3:0] + 4'd9)};
		return 5'h10;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
		if (n < 4'd10)
			return 8'("0") + 8'(n);
		return (lower ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
	endfunction

	function automatic nmea_rx_pkg::res_t parse_byte(input logic [7:0] b);
		nmea_rx_pkg::res_t r;
		logic [4:0] nib;
		r = '0;
		r.event_res = nmea_rx_pkg::EV_IGNORED;
		if (b == nmea_rx_pkg::CH_DOLLAR || b == nmea_rx_pkg::CH_BANG) begin
			dol = (b == nmea_rx_pkg::CH_DOLLAR);
			wpos = '0;
			nfields = '0;
			xor_acc = '0;
			given = '0;
			ph = nmea_rx_pkg::PH_RECV;
			r.event_res = nmea_rx_pkg::EV_START;
		end else if (ph == nmea_rx_pkg::PH_RECV || ph == nmea_rx_pkg::PH_FULL) begin
			if (b == nmea_rx_pkg::CH_STAR) begin
				ph = nmea_rx_pkg::PH_HIGH;
			end else if (ph == nmea_rx_pkg::PH_RECV) begin
				xor_acc = xor_acc ^ b;
				r.position = wpos;
				if (b == nmea_rx_pkg::CH_COMMA) begin
					r.event_res = nmea_rx_pkg::EV_SEP;
					if (nfields < FIELD_MAX)
						nfields = nfields + 5'd1;
				end else begin
					r.event_res = nmea_rx_pkg::EV_CHAR;
					r.char_out = b;
				end
				wpos = wpos + 7'd1;
				if (wpos >= BUF_LEN)
					ph = nmea_rx_pkg::PH_FULL;
			end else begin
				r.event_res = nmea_rx_pkg::EV_ABORT;
				ph = nmea_rx_pkg::PH_WAIT;
			end
		end else if (ph == nmea_rx_pkg::PH_HIGH) begin
			nib = nibble_of(b);
			if (nib[4]) begin
				r.event_res = nmea_rx_pkg::EV_REJECT;
				ph = nmea_rx_pkg::PH_WAIT;
			end else begin
				given = {nib[3:0], 4'h0};
				ph = nmea_rx_pkg::PH_LOW;
			end
		end else if (ph == nmea_rx_pkg::PH_LOW) begin
			nib = nibble_of(b);
			r.event_res = nmea_rx_pkg::EV_REJECT;
			if (!nib[4]) begin
				given = {given[7:4], nib[3:0]};
				if (given == xor_acc)
					r.event_res = nmea_rx_pkg::EV_ACCEPT;
			end
			ph = nmea_rx_pkg::PH_WAIT;
		end
		r.field_count = nfields;
		r.is_dollar = dol;
		r.checksum_calc = xor_acc;
		return r;
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		plan_item_t it;
		it.b = b;
		it.fixed = 1'b0;
		it.ev = nmea_rx_pkg::EV_IGNORED;
		it.dol = 1'b0;
		plan.push_back(it);
	endfunction

	task automatic flag_field(input string name, input int want, input int got);
		$display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
			$time, name, want, want, got, got);
		errors++;
	endtask

	// sender: holds valid and payload until the transfer
	always @(posedge clk) begin
		if (arst_n && (!in_valid || in_ready)) begin
			if (next_idx < plan.size() &&
					(calm || hold_left > 0 || $urandom_range(0, 99) >= 32)) begin
				in_valid <= 1'b1;
				rx_byte <= plan[next_idx].b;
				next_idx++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off to back up the input
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!pressed && acc_count >= 120) begin
			pressed <= 1'b1;
			hold_left <= 64;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(0, 99) >= 32);
		end
	end

	// output check first, then predict for the byte transferred at this edge
	always @(posedge clk) begin
		nmea_rx_pkg::res_t got;
		nmea_rx_pkg::res_t want;
		nmea_rx_pkg::res_t guess;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = {event_res, char_out, position, field_count, is_dollar, checksum_calc};
				if (parsed_q.size() == 0) begin
					$display("%0t: result with nothing pending, got event %0d",
						$time, got.event_res);
					errors++;
				end else begin
					want = parsed_q.pop_front();
					if (got.event_res !== want.event_res)
						flag_field("event_res", want.event_res, got.event_res);
					if (got.char_out !== want.char_out)
						flag_field("char_out", want.char_out, got.char_out);
					if (got.position !== want.position)
						flag_field("position", want.position, got.position);
					if (got.field_count !== want.field_count)
						flag_field("field_count", want.field_count, got.field_count);
					if (got.is_dollar !== want.is_dollar)
						flag_field("is_dollar", want.is_dollar, got.is_dollar);
					if (got.checksum_calc !== want.checksum_calc)
						flag_field("checksum_calc", want.checksum_calc, got.checksum_calc);
				end
				if (got.event_res == nmea_rx_pkg::EV_ACCEPT)
					n_accept++;
				if (got.event_res == nmea_rx_pkg::EV_REJECT)
					n_reject++;
				if (got.event_res == nmea_rx_pkg::EV_ABORT)
					n_abort++;
			end
			if (in_valid && in_ready) begin
				guess = parse_byte(rx_byte);
				if (plan[acc_count].fixed)
					guess = {plan[acc_count].ev, 8'h00, 7'h00, 5'h00, plan[acc_count].dol,
						8'h00};
				parsed_q.push_back(guess);
				acc_count <= acc_count + 1;
			end
		end
	end

	initial begin
		#400000;
		$display("%0t: timeout, %0d bytes transferred, %0d results pending",
			$time, acc_count, parsed_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int made;
		int len;
		int kind;
		int comma_pct;
		logic [7:0] b;
		logic [7:0] sum;
		logic [7:0] hi;
		logic [7:0] lo;
		logic [4:0] nib;
		bit lower;
		foreach (dir_rows[i])
			plan.push_back(dir_rows[i]);
		made = 0;
		while (made < RAND_BYTES) begin
			if ($urandom_range(0, 99) < 10) begin
				// line noise, may hold start marks of its own
				len = $urandom_range(1, 6);
				repeat (len)
					push_byte(8'($urandom_range(0, 255)));
				continue;
			end
			push_byte($urandom_range(0, 1) ? nmea_rx_pkg::CH_DOLLAR : nmea_rx_pkg::CH_BANG);
			made++;
			// a few sentences run up to and past the end of the buffer
			if ($urandom_range(0, 99) < 8)
				len = $urandom_range(BUF_LEN - 2, BUF_LEN + 5);
			else
				len = $urandom_range(0, 24);
			comma_pct = ($urandom_range(0, 9) == 0) ? 75 : 20;
			sum = 8'h00;
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 99) < comma_pct) begin
					b = nmea_rx_pkg::CH_COMMA;
				end else begin
					do
						b = 8'($urandom_range(0, 255));
					while (b == nmea_rx_pkg::CH_DOLLAR || b == nmea_rx_pkg::CH_BANG ||
						b == nmea_rx_pkg::CH_STAR);
				end
				sum = sum ^ b;
				push_byte(b);
				made++;
			end
			kind = $urandom_range(0, 99);
			// truncated: the next start cuts it off
			if (kind < 4)
				continue;
			push_byte(nmea_rx_pkg::CH_STAR);
			lower = $urandom_range(0, 1);
			if (kind < 12)
				sum = sum ^ (8'h01 << $urandom_range(0, 7));
			hi = hex_char(sum[7:4], lower);
			lo = hex_char(sum[3:0], lower);
			if (kind >= 12 && kind < 20) begin
				do begin
					b = 8'($urandom_range(0, 255));
					nib = nibble_of(b);
				end while (!nib[4] || b == nmea_rx_pkg::CH_DOLLAR ||
					b == nmea_rx_pkg::CH_BANG);
				if (kind < 16)
					hi = b;
				else
					lo = b;
			end else if (kind >= 20 && kind < 23) begin
				lo = nmea_rx_pkg::CH_DOLLAR;
			end
			push_byte(hi);
			push_byte(lo);
			made += 3;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (acc_count < plan.size())
			@(posedge clk);
		while (parsed_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("%0d bytes parsed (%0d directed), incl. a long output stall",
			acc_count, $size(dir_rows));
		$display("sentences seen: %0d accepted, %0d rejected, %0d aborted on a full buffer",
			n_accept, n_reject, n_abort);
		if (errors == 0 && parsed_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/nmea_rx_pkg.sv
rtl/core/nmea_rx_fsm.sv
rtl/core/nmea_sentence_receiver.sv
rtl/core/nmea_rx_checker.sv
tb/sv/testbench.sv
